// ----- hw/rtl/plne_pkg.sv -----
// Shared types, codes and sizes for the positional list engine.
package plne_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = 8;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_FIND   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PTR_CNT_M1 = 2'd0,
    PTR_POS_P1 = 2'd1,
    PTR_POS    = 2'd2,
    PTR_ZERO   = 2'd3
  } ptr_src_t;

  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_UP   = 2'd1,
    WR_DOWN = 2'd2,
    WR_VAL  = 2'd3
  } wr_sel_t;

  typedef struct packed {
    op_t                 operation;
    logic [CNT_W-1:0]    position;
    logic signed [31:0]  item_value;
  } item_t;

  typedef struct packed {
    status_t             status;
    logic signed [31:0]  read_value;
    logic [CNT_W-1:0]    found_index;
    logic [CNT_W-1:0]    list_length;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic     load;
    logic     ptr_ld;
    ptr_src_t ptr_src;
    logic     ptr_inc;
    logic     ptr_dec;
    logic     rd;
    wr_sel_t  wr_sel;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     emit;
    status_t  emit_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic full;
    logic cnt_zero;
    logic pos_is_last;
    logic ptr_eq_pos;
    logic ptr_is_last;
    logic match;
  } flags_t;

endpackage

// ----- hw/rtl/plne_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
module plne_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/plne_dp.sv -----
// Datapath: item registers, length count, address pointer, entry RAM, result register.
module plne_dp (
  input  logic               clk,
  input  logic               rst,
  input  plne_pkg::item_t    item,
  input  plne_pkg::cmd_t     cmd,
  output plne_pkg::flags_t   flags,
  output logic               done,
  output plne_pkg::result_t  result
);

  localparam logic [plne_pkg::CNT_W-1:0] CAP_CNT = plne_pkg::CNT_W'(plne_pkg::CAPACITY);

  plne_pkg::op_t                 op_r;
  logic [plne_pkg::CNT_W-1:0]    pos_r;
  logic [plne_pkg::DATA_W-1:0]   val_r;
  logic [plne_pkg::CNT_W-1:0]    count;
  logic [plne_pkg::CNT_W-1:0]    count_next;
  logic [plne_pkg::CNT_W-1:0]    count_m1;
  logic [plne_pkg::CNT_W-1:0]    ptr;
  logic [plne_pkg::CNT_W-1:0]    rd_addr_q;

  logic                          wr_en;
  logic [plne_pkg::ADDR_W-1:0]   waddr;
  logic [plne_pkg::DATA_W-1:0]   wdata;
  logic [plne_pkg::ADDR_W-1:0]   raddr;
  logic [plne_pkg::DATA_W-1:0]   rdata;

  assign count_m1 = count - plne_pkg::CNT_W'(1);
  assign raddr    = ptr[plne_pkg::ADDR_W-1:0];

  always_comb begin
    count_next = count;
    if (cmd.cnt_inc) begin
      count_next = count + plne_pkg::CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_next = count_m1;
    end
  end

  always_comb begin
    wr_en = 1'b1;
    waddr = pos_r[plne_pkg::ADDR_W-1:0];
    wdata = rdata;
    case (cmd.wr_sel)
      plne_pkg::WR_UP: begin
        waddr = plne_pkg::ADDR_W'(rd_addr_q + plne_pkg::CNT_W'(1));
      end
      plne_pkg::WR_DOWN: begin
        waddr = plne_pkg::ADDR_W'(rd_addr_q - plne_pkg::CNT_W'(1));
      end
      plne_pkg::WR_VAL: begin
        wdata = val_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  plne_ram #(
    .WIDTH (plne_pkg::DATA_W),
    .DEPTH (plne_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= item.operation;
      pos_r <= item.position;
      val_r <= item.item_value;
    end
    if (cmd.ptr_ld) begin
      case (cmd.ptr_src)
        plne_pkg::PTR_CNT_M1: ptr <= count_m1;
        plne_pkg::PTR_POS_P1: ptr <= pos_r + plne_pkg::CNT_W'(1);
        plne_pkg::PTR_POS:    ptr <= pos_r;
        default:              ptr <= '0;
      endcase
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + plne_pkg::CNT_W'(1);
    end else if (cmd.ptr_dec) begin
      ptr <= ptr - plne_pkg::CNT_W'(1);
    end
    if (cmd.rd) begin
      rd_addr_q <= ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= cmd.emit;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.status      <= cmd.emit_status;
      result.list_length <= count_next;
      result.read_value  <= (op_r == plne_pkg::OP_READ && cmd.emit_status == plne_pkg::ST_OK)
                            ? rdata : '0;
      result.found_index <= (op_r == plne_pkg::OP_FIND && cmd.emit_status == plne_pkg::ST_OK)
                            ? rd_addr_q : '0;
    end
  end

  always_comb begin
    flags.op          = op_r;
    flags.pos_gt_cnt  = pos_r > count;
    flags.pos_ge_cnt  = pos_r >= count;
    flags.full        = count >= CAP_CNT;
    flags.cnt_zero    = count == '0;
    flags.pos_is_last = pos_r == count_m1;
    flags.ptr_eq_pos  = ptr == pos_r;
    flags.ptr_is_last = ptr == count_m1;
    flags.match       = rdata == val_r;
  end

  // shift pipeline never reads the entry it is writing
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (wr_en && cmd.rd) |-> (waddr != raddr))
    else $error("read and write hit the same entry");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> (count < CAP_CNT))
    else $error("length grows past capacity");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |-> (count != '0))
    else $error("length drops below zero");

  a_single_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

endmodule

// ----- hw/rtl/plne_ctrl.sv -----
// Controller: sequences checks, shift passes, reads and searches for each item.
module plne_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  plne_pkg::flags_t  flags,
  output logic              busy,
  output plne_pkg::cmd_t    cmd
);

  typedef enum logic [13:0] {
    S_IDLE       = 14'b00000000000001,
    S_CHECK      = 14'b00000000000010,
    S_UP_PRIME   = 14'b00000000000100,
    S_UP_RUN     = 14'b00000000001000,
    S_UP_LAST    = 14'b00000000010000,
    S_INS_WRITE  = 14'b00000000100000,
    S_DN_PRIME   = 14'b00000001000000,
    S_DN_RUN     = 14'b00000010000000,
    S_DN_LAST    = 14'b00000100000000,
    S_RD_ISSUE   = 14'b00001000000000,
    S_RD_WAIT    = 14'b00010000000000,
    S_FIND_PRIME = 14'b00100000000000,
    S_FIND_RUN   = 14'b01000000000000,
    S_FIND_TAIL  = 14'b10000000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.ptr_src     = plne_pkg::PTR_ZERO;
    cmd.wr_sel      = plne_pkg::WR_NONE;
    cmd.emit_status = plne_pkg::ST_OK;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        case (flags.op)
          plne_pkg::OP_INSERT: begin
            if (flags.pos_gt_cnt) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = plne_pkg::ST_RANGE;
              state_next      = S_IDLE;
            end else if (flags.full) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = plne_pkg::ST_FULL;
              state_next      = S_IDLE;
            end else if (flags.pos_ge_cnt) begin
              state_next = S_INS_WRITE;   // append, nothing to move
            end else begin
              cmd.ptr_ld  = 1'b1;
              cmd.ptr_src = plne_pkg::PTR_CNT_M1;
              state_next  = S_UP_PRIME;
            end
          end
          plne_pkg::OP_DELETE: begin
            if (flags.pos_ge_cnt) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = plne_pkg::ST_RANGE;
              state_next      = S_IDLE;
            end else if (flags.pos_is_last) begin
              cmd.cnt_dec = 1'b1;
              cmd.emit    = 1'b1;
              state_next  = S_IDLE;
            end else begin
              cmd.ptr_ld  = 1'b1;
              cmd.ptr_src = plne_pkg::PTR_POS_P1;
              state_next  = S_DN_PRIME;
            end
          end
          plne_pkg::OP_READ: begin
            if (flags.pos_ge_cnt) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = plne_pkg::ST_RANGE;
              state_next      = S_IDLE;
            end else begin
              cmd.ptr_ld  = 1'b1;
              cmd.ptr_src = plne_pkg::PTR_POS;
              state_next  = S_RD_ISSUE;
            end
          end
          default: begin
            if (flags.cnt_zero) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = plne_pkg::ST_MISSING;
              state_next      = S_IDLE;
            end else begin
              cmd.ptr_ld  = 1'b1;
              cmd.ptr_src = plne_pkg::PTR_ZERO;
              state_next  = S_FIND_PRIME;
            end
          end
        endcase
      end
      // shift up: read entry ptr, write it one place higher in the next cycle
      S_UP_PRIME, S_UP_RUN: begin
        cmd.rd = 1'b1;
        if (state == S_UP_RUN) begin
          cmd.wr_sel = plne_pkg::WR_UP;
        end
        if (flags.ptr_eq_pos) begin
          state_next = S_UP_LAST;
        end else begin
          cmd.ptr_dec = 1'b1;
          state_next  = S_UP_RUN;
        end
      end
      S_UP_LAST: begin
        cmd.wr_sel = plne_pkg::WR_UP;
        state_next = S_INS_WRITE;
      end
      S_INS_WRITE: begin
        cmd.wr_sel  = plne_pkg::WR_VAL;
        cmd.cnt_inc = 1'b1;
        cmd.emit    = 1'b1;
        state_next  = S_IDLE;
      end
      // shift down: read entry ptr, write it one place lower in the next cycle
      S_DN_PRIME, S_DN_RUN: begin
        cmd.rd = 1'b1;
        if (state == S_DN_RUN) begin
          cmd.wr_sel = plne_pkg::WR_DOWN;
        end
        if (flags.ptr_is_last) begin
          state_next = S_DN_LAST;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next  = S_DN_RUN;
        end
      end
      S_DN_LAST: begin
        cmd.wr_sel  = plne_pkg::WR_DOWN;
        cmd.cnt_dec = 1'b1;
        cmd.emit    = 1'b1;
        state_next  = S_IDLE;
      end
      S_RD_ISSUE: begin
        cmd.rd     = 1'b1;
        state_next = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      S_FIND_PRIME: begin
        cmd.rd = 1'b1;
        if (flags.ptr_is_last) begin
          state_next = S_FIND_TAIL;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next  = S_FIND_RUN;
        end
      end
      // compare the entry read last cycle; stop on the first hit
      S_FIND_RUN: begin
        if (flags.match) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.rd = 1'b1;
          if (flags.ptr_is_last) begin
            state_next = S_FIND_TAIL;
          end else begin
            cmd.ptr_inc = 1'b1;
          end
        end
      end
      S_FIND_TAIL: begin
        cmd.emit = 1'b1;
        if (!flags.match) begin
          cmd.emit_status = plne_pkg::ST_MISSING;
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_start_loads: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_CHECK))
    else $error("accepted item not taken into check");

  a_emit_ends_item: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> !busy)
    else $error("result given while work continues");

  a_no_read_and_write_val: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_sel == plne_pkg::WR_VAL) |-> (!cmd.rd && !cmd.ptr_inc && !cmd.ptr_dec))
    else $error("value write overlaps a shift pass");

endmodule

// ----- hw/rtl/positional_list_engine_unit.sv -----
// Top level of the positional list engine: controller plus datapath.
//
//  channel  | handshake             | payload             | transfer when
//  ---------+-----------------------+---------------------+----------------------
//  item in  | start / busy          | item  (item_t)      | start high, busy low
//  result   | done (one-cycle pulse)| result (result_t)   | every cycle done is high
//
// An item whose position or length check fails, or that removes the last entry,
// ends at the check; an append goes to the value write, a read issues its read
// and then takes the data, an insert or delete first shifts the entries it moves,
// and a find scans until its first hit or the last entry; the entry RAM gives one
// registered read per cycle, so the shift and search passes move one entry a cycle.
// busy is low on the cycle the result strobe rises, so the next item can transfer then.
// Synchronous reset empties the list; the entry RAM itself is not cleared.
// The result channel has no stall: each result is valid for exactly one cycle.
module positional_list_engine_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  plne_pkg::item_t    item,
  output logic               done,
  output plne_pkg::result_t  result
);

  plne_pkg::cmd_t   cmd;
  plne_pkg::flags_t flags;

  plne_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .busy  (busy),
    .cmd   (cmd)
  );

  plne_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .flags  (flags),
    .done   (done),
    .result (result)
  );

endmodule

// ----- bench/tb_positional_list_engine_unit.sv -----
// Self-checking testbench for the positional list engine: directed and random list operations.
`timescale 1ns / 1ps

module tb_positional_list_engine_unit;

  localparam int ITEM_TARGET = 1950;
  localparam int STALL_LIMIT = 2000;  // covers the longest op plus the largest idle gap
  localparam int SETTLE_CYCLES = 80;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  plne_pkg::item_t   item;
  logic              done;
  plne_pkg::result_t result;

  positional_list_engine_unit dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  // shadow copy of the list contents
  logic signed [31:0] shadow_list [plne_pkg::CAPACITY];
  int                 shadow_len;
  plne_pkg::result_t  pending_results [$];

  int gap_max;
  int err_count;
  int n_items;
  int n_checked;
  int max_len;
  int idle_cycles;
  int status_tally [4];

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Apply one operation to the shadow list and return the result it should produce.
  function automatic plne_pkg::result_t apply_list_op(input plne_pkg::item_t it);
    plne_pkg::result_t r;
    int p;
    r = '0;
    r.status = plne_pkg::ST_OK;
    p = it.position;
    case (it.operation)
      plne_pkg::OP_INSERT: begin
        if (p > shadow_len) begin
          r.status = plne_pkg::ST_RANGE;
        end else if (shadow_len >= plne_pkg::CAPACITY) begin
          r.status = plne_pkg::ST_FULL;
        end else begin
          for (int i = shadow_len; i > p; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p] = it.item_value;
          shadow_len++;
        end
      end
      plne_pkg::OP_DELETE: begin
        if (p >= shadow_len) begin
          r.status = plne_pkg::ST_RANGE;
        end else begin
          for (int i = p; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      plne_pkg::OP_READ: begin
        if (p >= shadow_len) r.status = plne_pkg::ST_RANGE;
        else r.read_value = shadow_list[p];
      end
      default: begin
        r.status = plne_pkg::ST_MISSING;
        for (int i = 0; i < shadow_len; i++) begin
          if (shadow_list[i] == it.item_value) begin
            r.status = plne_pkg::ST_OK;
            r.found_index = 8'(i);
            break;
          end
        end
      end
    endcase
    r.list_length = 8'(shadow_len);
    return r;
  endfunction

  // One transfer on the command side; start stays high into the next call when it has no gap.
  task automatic send_list_op(input plne_pkg::op_t op, input logic [7:0] pos,
                              input logic [31:0] val);
    plne_pkg::item_t   it;
    plne_pkg::result_t r;
    int                gap;
    it.operation  = op;
    it.position   = pos;
    it.item_value = val;
    gap = $urandom_range(0, gap_max);
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    item  <= it;
    forever begin
      @(posedge clk);
      if (busy === 1'b0) break;
    end
    r = apply_list_op(it);
    pending_results.push_back(r);
    status_tally[r.status]++;
    n_items++;
    if (shadow_len > max_len) max_len = shadow_len;
  endtask

  // Mix of corner values, values already in the list (so finds hit) and plain random words.
  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      case ($urandom_range(0, 4))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'hFFFF_FFFF;
        3: return 32'h0000_0000;
        default: return 32'h0000_0001;
      endcase
    end
    if (sel < 50 && shadow_len > 0) return shadow_list[$urandom_range(0, shadow_len - 1)];
    return $urandom;
  endfunction

  task automatic send_random_op(input int w_ins, input int w_del, input int w_read);
    plne_pkg::op_t op;
    int            sel;
    int            span;
    logic [7:0]    pos;
    sel = $urandom_range(0, 99);
    if (sel < w_ins) op = plne_pkg::OP_INSERT;
    else if (sel < w_ins + w_del) op = plne_pkg::OP_DELETE;
    else if (sel < w_ins + w_del + w_read) op = plne_pkg::OP_READ;
    else op = plne_pkg::OP_FIND;
    span = (op == plne_pkg::OP_INSERT) ? shadow_len : shadow_len - 1;
    sel = $urandom_range(0, 99);
    if (op != plne_pkg::OP_FIND && span >= 0 && sel < 80) pos = 8'($urandom_range(0, span));
    else if (sel < 88) pos = 8'(shadow_len);  // first bad position for delete and read
    else pos = 8'($urandom_range(0, 255));
    send_list_op(op, pos, pick_value());
  endtask

  task automatic choose_idling();
    case ($urandom_range(0, 2))
      0: gap_max = 0;
      1: gap_max = 3;
      default: gap_max = 10;
    endcase
  endtask

  task automatic test_empty_list();
    send_list_op(plne_pkg::OP_READ,   8'd0,   32'h0);
    send_list_op(plne_pkg::OP_DELETE, 8'd0,   32'h1234_5678);
    send_list_op(plne_pkg::OP_DELETE, 8'd255, 32'h0);
    send_list_op(plne_pkg::OP_FIND,   8'd0,   32'h0);
    send_list_op(plne_pkg::OP_INSERT, 8'd1,   32'h5);
    send_list_op(plne_pkg::OP_READ,   8'd255, 32'hFFFF_FFFF);
  endtask

  task automatic test_insert_order_and_extremes();
    send_list_op(plne_pkg::OP_INSERT, 8'd0,   32'h8000_0000);
    send_list_op(plne_pkg::OP_INSERT, 8'd1,   32'h7FFF_FFFF);  // append
    send_list_op(plne_pkg::OP_INSERT, 8'd0,   32'hFFFF_FFFF);  // front
    send_list_op(plne_pkg::OP_INSERT, 8'd1,   32'h0000_0000);  // middle
    send_list_op(plne_pkg::OP_INSERT, 8'd4,   32'h7FFF_FFFF);  // duplicate at the end
    send_list_op(plne_pkg::OP_INSERT, 8'd6,   32'h1);          // past the end
    send_list_op(plne_pkg::OP_INSERT, 8'd255, 32'h1);
    send_list_op(plne_pkg::OP_READ,   8'd0,   32'hDEAD_BEEF);
    send_list_op(plne_pkg::OP_READ,   8'd2,   32'h0);
    send_list_op(plne_pkg::OP_READ,   8'd4,   32'h0);
    send_list_op(plne_pkg::OP_READ,   8'd5,   32'h0);
    send_list_op(plne_pkg::OP_FIND,   8'd200, 32'h7FFF_FFFF);  // first of two matches
    send_list_op(plne_pkg::OP_FIND,   8'd0,   32'h8000_0000);
    send_list_op(plne_pkg::OP_FIND,   8'd0,   32'h0001_2345);
    send_list_op(plne_pkg::OP_DELETE, 8'd4,   32'hFFFF_FFFF);  // last
    send_list_op(plne_pkg::OP_DELETE, 8'd0,   32'h0);          // front
    send_list_op(plne_pkg::OP_DELETE, 8'd1,   32'h0);          // middle
  endtask

  task automatic test_full_store();
    for (int round = 0; round < 3; round++) begin
      choose_idling();
      while (shadow_len < plne_pkg::CAPACITY) send_random_op(80, 5, 10);
      // valid position, no room
      send_list_op(plne_pkg::OP_INSERT, 8'(plne_pkg::CAPACITY), $urandom);
      send_list_op(plne_pkg::OP_INSERT, 8'd0, $urandom);
      // range check wins
      send_list_op(plne_pkg::OP_INSERT, 8'(plne_pkg::CAPACITY + 1), $urandom);
      send_list_op(plne_pkg::OP_READ,   8'(plne_pkg::CAPACITY - 1), 32'h0);
      send_list_op(plne_pkg::OP_READ,   8'(plne_pkg::CAPACITY), 32'h0);
      repeat (25) send_random_op(40, 20, 20);
    end
  endtask

  task automatic test_drain_to_empty();
    for (int round = 0; round < 3; round++) begin
      choose_idling();
      while (shadow_len > 0) send_random_op(5, 80, 10);
      repeat (15) send_random_op(25, 25, 25);
      while (shadow_len < 20) send_random_op(70, 10, 10);
    end
  endtask

  task automatic test_mixed_random();
    while (n_items < ITEM_TARGET) begin
      if (n_items % 50 == 0) choose_idling();
      send_random_op(30, 25, 20);
    end
  endtask

  // Result checker and stall watchdog
  always @(posedge clk) begin
    plne_pkg::result_t expd;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (done === 1'b1) begin
        n_checked++;
        if (pending_results.size() == 0) begin
          $error("result with no operation outstanding: %p", result);
          err_count++;
        end else begin
          expd = pending_results.pop_front();
          if (result.status !== expd.status) begin
            $error("status: expected %0d, got %0d", expd.status, result.status);
            err_count++;
          end
          if (result.read_value !== expd.read_value) begin
            $error("read_value: expected %0d, got %0d", expd.read_value, result.read_value);
            err_count++;
          end
          if (result.found_index !== expd.found_index) begin
            $error("found_index: expected %0d, got %0d", expd.found_index, result.found_index);
            err_count++;
          end
          if (result.list_length !== expd.list_length) begin
            $error("list_length: expected %0d, got %0d", expd.list_length, result.list_length);
            err_count++;
          end
        end
      end
      if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no transfer for %0d cycles, %0d results outstanding",
                 idle_cycles, pending_results.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst        = 1'b1;
    start      <= 1'b0;
    item       <= '0;
    gap_max    = 10;
    err_count  = 0;
    n_items    = 0;
    n_checked  = 0;
    max_len    = 0;
    shadow_len = 0;
    status_tally = '{0, 0, 0, 0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_list();
    test_insert_order_and_extremes();
    test_full_store();
    test_drain_to_empty();
    test_mixed_random();

    @(negedge clk);
    start <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d operations, %0d results checked; list peaked at %0d of %0d entries",
             n_items, n_checked, max_len, plne_pkg::CAPACITY);
    $display("status mix: %0d ok, %0d bad position, %0d full, %0d not found",
             status_tally[plne_pkg::ST_OK], status_tally[plne_pkg::ST_RANGE],
             status_tally[plne_pkg::ST_FULL], status_tally[plne_pkg::ST_MISSING]);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
